// File: src/irn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irn_pkg
// Shared constants and types of the image resampler.
// ----------------------------------------------------------------------------
package irn_pkg;

   localparam int MAX_SRC_WIDTH_DEF  = 256;
   localparam int MAX_SRC_HEIGHT_DEF = 256;
   localparam int SAMPLE_BITS_DEF    = 16;

   localparam int Q_DEPTH    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int TGT_W      = 13;
   localparam int POS_W      = 12;
   localparam int PIX_W      = 16;
   localparam int FRAC_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TGT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TGT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd4;

   localparam logic [8:0]  SRC_SIZE_RST = 9'd256;
   localparam logic [12:0] TGT_SIZE_RST = 13'd256;

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_QUERY    = 1'b1;
   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   localparam logic [16:0] Q16_ONE  = 17'h10000;
   localparam logic [15:0] Q16_HALF = 16'h8000;

   typedef struct packed {
      logic query;
      logic err;
   } irn_ctl_type;

endpackage

// File: src/irn_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irn_div
// Restoring divider, one quotient bit per cycle, for the scale ratio.
// ----------------------------------------------------------------------------
module irn_div #(
   parameter int NW = 25
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [NW-1:0]                 dividend,
   input  wire logic [irn_pkg::TGT_W-1:0]     divisor,
   output logic                               busy,
   output logic [NW-1:0]                      quotient
);

   localparam int CW = $clog2(NW + 1);

   logic                        busy_ff, busy_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [NW-1:0]               num_ff, num_in;
   logic [NW-1:0]               quo_ff, quo_in;
   logic [irn_pkg::TGT_W-1:0]   rem_ff, rem_in;
   logic [irn_pkg::TGT_W-1:0]   dvs_ff, dvs_in;
   logic [irn_pkg::TGT_W:0]     rem_sh, rem_step;
   logic                        ge;

   always_comb begin
      rem_sh   = {rem_ff, num_ff[NW-1]};
      ge       = rem_sh >= {1'b0, dvs_ff};
      rem_step = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = rem_step[irn_pkg::TGT_W-1:0];
         num_in  = num_ff << 1;
         quo_in  = {quo_ff[NW-2:0], ge};
         cnt_in  = cnt_ff + CW'(1);
         busy_in = cnt_ff != CW'(NW - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: src/irn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irn_front
// Takes words, checks ranges, maps output positions to source neighbors.
// ----------------------------------------------------------------------------
module irn_front #(
   parameter int XW   = 8,
   parameter int YW   = 8,
   parameter int SWW  = 9,
   parameter int SHW  = 9,
   parameter int SB   = 16,
   parameter int DW   = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_func,
   input  wire logic [irn_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic [irn_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic [irn_pkg::PIX_W-1:0]     req_sample_in,
   input  wire logic                          div_busy,
   input  wire logic [SWW-1:0]                sw_eff,
   input  wire logic [SHW-1:0]                sh_eff,
   input  wire logic [irn_pkg::TGT_W-1:0]     tw_eff,
   input  wire logic [irn_pkg::TGT_W-1:0]     th_eff,
   input  wire logic                          mode,
   input  wire logic [SWW+15:0]               scale_x,
   input  wire logic [SHW+15:0]               scale_y,
   input  wire logic                          q_full,
   output logic                               q_push,
   output irn_pkg::irn_ctl_type               q_ctl,
   output logic [DW-1:0]                      q_data
);

   localparam int NWX = SWW + 16;
   localparam int NWY = SHW + 16;
   localparam int PWX = NWX + 13;
   localparam int PWY = NWY + 13;
   localparam int HWX = PWX - 1;
   localparam int HWY = PWY - 1;
   localparam int RWX = HWX - 16;
   localparam int RWY = HWY - 16;

   logic                          a_valid_ff, a_valid_in;
   logic                          a_func_ff;
   logic [irn_pkg::POS_W-1:0]     a_px_ff, a_py_ff;
   logic [SB-1:0]                 a_sample_ff;
   logic [47:0]                   sample_ext;

   logic                          p_valid_ff;
   logic                          p_query_ff, p_err_ff, p_wr_ok_ff;
   logic [PWX-1:0]                p_prodx_ff;
   logic [PWY-1:0]                p_prody_ff;
   logic [XW-1:0]                 p_x_ff;
   logic [YW-1:0]                 p_y_ff;
   logic [SB-1:0]                 p_sample_ff;

   logic                          a_take, p_adv, accept;

   logic [HWX-1:0]                halfx, sx;
   logic [HWY-1:0]                halfy, sy;
   logic [RWX-1:0]                rawx, limx, x0w, x1w;
   logic [RWY-1:0]                rawy, limy, y0w, y1w;
   logic [XW-1:0]                 x0, x1;
   logic [YW-1:0]                 y0, y1;
   logic [irn_pkg::FRAC_W-1:0]    fx, fy;

   assign p_adv     = !p_valid_ff || !q_full;
   assign a_take    = !a_valid_ff || p_adv;
   assign req_stall = !a_take || div_busy;
   assign accept    = req_valid && !req_stall;
   assign a_valid_in = a_take ? accept : a_valid_ff;
   assign sample_ext = {32'd0, req_sample_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (p_adv) begin
            p_valid_ff <= a_valid_ff;
         end
      end
      if (accept) begin
         a_func_ff   <= req_func;
         a_px_ff     <= req_pos_x;
         a_py_ff     <= req_pos_y;
         a_sample_ff <= sample_ext[SB-1:0];
      end
      if (p_adv) begin
         p_query_ff  <= a_func_ff == irn_pkg::FUNC_QUERY;
         p_err_ff    <= ({1'b0, a_px_ff} >= tw_eff) || ({1'b0, a_py_ff} >= th_eff);
         p_wr_ok_ff  <= ({1'b0, a_px_ff} < 13'(sw_eff)) && ({1'b0, a_py_ff} < 13'(sh_eff));
         p_prodx_ff  <= PWX'({a_px_ff, 1'b1}) * PWX'(scale_x);
         p_prody_ff  <= PWY'({a_py_ff, 1'b1}) * PWY'(scale_y);
         p_x_ff      <= a_px_ff[XW-1:0];
         p_y_ff      <= a_py_ff[YW-1:0];
         p_sample_ff <= a_sample_ff;
      end
   end

   // src = half - 0.5; nearest index is half >> 16 in every case
   always_comb begin
      halfx = p_prodx_ff[PWX-1:1];
      halfy = p_prody_ff[PWY-1:1];
      sx    = halfx - HWX'(irn_pkg::Q16_HALF);
      sy    = halfy - HWY'(irn_pkg::Q16_HALF);
      if (mode == irn_pkg::MODE_BILINEAR) begin
         rawx = (halfx < HWX'(irn_pkg::Q16_HALF)) ? '0 : sx[HWX-1:16];
         rawy = (halfy < HWY'(irn_pkg::Q16_HALF)) ? '0 : sy[HWY-1:16];
         fx   = sx[15:0];
         fy   = sy[15:0];
      end else begin
         rawx = halfx[HWX-1:16];
         rawy = halfy[HWY-1:16];
         fx   = '0;
         fy   = '0;
      end
      limx = RWX'(sw_eff) - RWX'(1);
      limy = RWY'(sh_eff) - RWY'(1);
      x0w  = (rawx > limx) ? limx : rawx;
      y0w  = (rawy > limy) ? limy : rawy;
      x0   = x0w[XW-1:0];
      y0   = y0w[YW-1:0];
      x1w  = (RWX'(x0) + RWX'(1) > limx) ? limx : RWX'(x0) + RWX'(1);
      y1w  = (RWY'(y0) + RWY'(1) > limy) ? limy : RWY'(y0) + RWY'(1);
      x1   = x1w[XW-1:0];
      y1   = y1w[YW-1:0];
   end

   assign q_push    = p_valid_ff && !q_full && (p_query_ff || p_wr_ok_ff);
   assign q_ctl.query = p_query_ff;
   assign q_ctl.err   = p_err_ff;
   assign q_data = p_query_ff ? {x0, x1, y0, y1, fx, fy, p_sample_ff}
                              : {p_x_ff, x1, p_y_ff, y1, fx, fy, p_sample_ff};

endmodule
`default_nettype wire

// File: src/irn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irn_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module irn_queue #(
   parameter int DW = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire irn_pkg::irn_ctl_type  push_ctl,
   input  wire logic [DW-1:0]         push_data,
   output logic                       full,
   output logic                       empty,
   input  wire logic                  pop,
   output irn_pkg::irn_ctl_type       head_ctl,
   output logic [DW-1:0]              head_data
);

   localparam int D  = irn_pkg::Q_DEPTH;
   localparam int PW = $clog2(D);
   localparam int CW = $clog2(D + 1);

   irn_pkg::irn_ctl_type  ctl_ff [D];
   logic [DW-1:0]         data_ff [D];
   logic [PW-1:0]         wp_ff, rp_ff;
   logic [CW-1:0]         cnt_ff;

   assign full      = cnt_ff == CW'(D);
   assign empty     = cnt_ff == '0;
   assign head_ctl  = ctl_ff[rp_ff];
   assign head_data = data_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + PW'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + PW'(1);
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(pop);
      end
      if (push) begin
         ctl_ff[wp_ff]  <= push_ctl;
         data_ff[wp_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: src/irn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irn_back
// Parity-banked frame store and the bilinear weighting pipeline.
// ----------------------------------------------------------------------------
module irn_back #(
   parameter int XW = 8,
   parameter int YW = 8,
   parameter int SB = 16,
   parameter int DW = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire irn_pkg::irn_ctl_type          q_ctl,
   input  wire logic [DW-1:0]                 q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [irn_pkg::PIX_W-1:0]          rsp_pixel_value,
   output logic                               rsp_status
);

   localparam int BAW = XW - 1 + YW - 1;
   localparam int BD  = 1 << BAW;
   localparam int AW  = SB + 17;
   localparam int TW  = AW + 17;
   localparam int RW  = (SB + 2 > 17) ? SB + 2 : 17;

   logic [XW-1:0]                 h_x0, h_x1;
   logic [YW-1:0]                 h_y0, h_y1;
   logic [irn_pkg::FRAC_W-1:0]    h_fx, h_fy;
   logic [SB-1:0]                 h_sample;
   logic                          adv, wr;
   logic [SB-1:0]                 bank_rd [4];

   logic                          r_valid_ff, r_err_ff;
   logic [irn_pkg::FRAC_W-1:0]    r_fx_ff, r_fy_ff;
   logic                          r_x0p_ff, r_x1p_ff, r_y0p_ff, r_y1p_ff;
   logic                          m1_valid_ff, m1_err_ff;
   logic [AW-1:0]                 m1_a0_ff, m1_a1_ff;
   logic [irn_pkg::FRAC_W-1:0]    m1_fy_ff;
   logic                          m2_valid_ff, m2_err_ff;
   logic [TW-1:0]                 m2_t_ff;
   logic                          rsp_valid_ff, rsp_status_ff;
   logic [irn_pkg::PIX_W-1:0]     rsp_pixel_ff;

   logic [SB-1:0]                 v00, v10, v01, v11;
   logic [16:0]                   wx0, wx1, wy0, wy1;
   logic [AW-1:0]                 a0, a1;
   logic [TW-1:0]                 t, tsum;
   logic [RW-1:0]                 resw;

   assign {h_x0, h_x1, h_y0, h_y1, h_fx, h_fy, h_sample} = q_data;
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_empty;
   assign wr    = q_pop && !q_ctl.query;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic XP = 1'(b % 2);
      localparam logic YP = 1'(b / 2);
      logic [SB-1:0]  mem [BD];
      logic [XW-1:0]  cx;
      logic [YW-1:0]  ry;
      logic [BAW-1:0] raddr, waddr;
      logic           we;

      always_comb begin
         cx    = (h_x0[0] == XP) ? h_x0 : h_x1;
         ry    = (h_y0[0] == YP) ? h_y0 : h_y1;
         raddr = {ry[YW-1:1], cx[XW-1:1]};
         waddr = {h_y0[YW-1:1], h_x0[XW-1:1]};
         we    = wr && (h_x0[0] == XP) && (h_y0[0] == YP);
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= h_sample;
         end
         if (adv) begin
            bank_rd[b] <= mem[raddr];
         end
      end
   end

   always_comb begin
      v00 = r_y0p_ff ? (r_x0p_ff ? bank_rd[3] : bank_rd[2])
                     : (r_x0p_ff ? bank_rd[1] : bank_rd[0]);
      v10 = r_y0p_ff ? (r_x1p_ff ? bank_rd[3] : bank_rd[2])
                     : (r_x1p_ff ? bank_rd[1] : bank_rd[0]);
      v01 = r_y1p_ff ? (r_x0p_ff ? bank_rd[3] : bank_rd[2])
                     : (r_x0p_ff ? bank_rd[1] : bank_rd[0]);
      v11 = r_y1p_ff ? (r_x1p_ff ? bank_rd[3] : bank_rd[2])
                     : (r_x1p_ff ? bank_rd[1] : bank_rd[0]);
      wx1  = {1'b0, r_fx_ff};
      wx0  = irn_pkg::Q16_ONE - wx1;
      wy1  = {1'b0, m1_fy_ff};
      wy0  = irn_pkg::Q16_ONE - wy1;
      a0   = AW'(v00) * AW'(wx0) + AW'(v10) * AW'(wx1);
      a1   = AW'(v01) * AW'(wx0) + AW'(v11) * AW'(wx1);
      t    = TW'(m1_a0_ff) * TW'(wy0) + TW'(m1_a1_ff) * TW'(wy1);
      tsum = m2_t_ff + (TW'(1) << 31);
      resw = RW'(tsum >> 32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         r_valid_ff   <= q_pop && q_ctl.query;
         m1_valid_ff  <= r_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         rsp_valid_ff <= m2_valid_ff;
      end
      if (adv) begin
         r_err_ff      <= q_ctl.err;
         r_fx_ff       <= h_fx;
         r_fy_ff       <= h_fy;
         r_x0p_ff      <= h_x0[0];
         r_x1p_ff      <= h_x1[0];
         r_y0p_ff      <= h_y0[0];
         r_y1p_ff      <= h_y1[0];
         m1_err_ff     <= r_err_ff;
         m1_a0_ff      <= a0;
         m1_a1_ff      <= a1;
         m1_fy_ff      <= r_fy_ff;
         m2_err_ff     <= m1_err_ff;
         m2_t_ff       <= t;
         rsp_status_ff <= m2_err_ff;
         if (m2_err_ff) begin
            rsp_pixel_ff <= '0;
         end else if (resw > RW'(16'hFFFF)) begin
            rsp_pixel_ff <= 16'hFFFF;
         end else begin
            rsp_pixel_ff <= resw[irn_pkg::PIX_W-1:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
`default_nettype wire

// File: src/image_resample_nearest_bilinear.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_resample_nearest_bilinear
// Single-band nearest / bilinear resampler with an on-chip frame store.
//
//   port group  dir  contents
//   req_*       in   func, pos_x, pos_y, sample_in  (load or query word)
//   rsp_*       out  pixel_value, status            (one word per query)
//   csr_*       in   write enable, index, data      (size and mode registers)
//
// One word per cycle in both directions while neither side stalls. Four
// parity banks of the store give all four neighbors at once. After reset
// and after every register write the two scale dividers run, and req_stall
// stays high meanwhile. rsp_stall holds the back end; the queue then fills
// and req_stall rises.
// ----------------------------------------------------------------------------
module image_resample_nearest_bilinear #(
   parameter int MAX_SRC_WIDTH  = irn_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = irn_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int SAMPLE_BITS    = irn_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_func,
   input  wire logic [irn_pkg::POS_W-1:0]         req_pos_x,
   input  wire logic [irn_pkg::POS_W-1:0]         req_pos_y,
   input  wire logic [irn_pkg::PIX_W-1:0]         req_sample_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [irn_pkg::PIX_W-1:0]              rsp_pixel_value,
   output logic                                   rsp_status,
   input  wire logic                              csr_we,
   input  wire logic [irn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [irn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int XW  = ($clog2(MAX_SRC_WIDTH) < 2) ? 2 : $clog2(MAX_SRC_WIDTH);
   localparam int YW  = ($clog2(MAX_SRC_HEIGHT) < 2) ? 2 : $clog2(MAX_SRC_HEIGHT);
   localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int NWX = SWW + 16;
   localparam int NWY = SHW + 16;
   localparam int DW  = 2 * XW + 2 * YW + 2 * irn_pkg::FRAC_W + SAMPLE_BITS;

   logic [8:0]                  src_w_ff, src_h_ff;
   logic [irn_pkg::TGT_W-1:0]   tgt_w_ff, tgt_h_ff;
   logic                        mode_ff;
   logic                        start_ff;

   logic [12:0]                 sw_c, sh_c;
   logic [SWW-1:0]              sw_eff;
   logic [SHW-1:0]              sh_eff;
   logic [irn_pkg::TGT_W-1:0]   tw_eff, th_eff;
   logic [NWX-1:0]              scale_x;
   logic [NWY-1:0]              scale_y;
   logic                        busy_x, busy_y, div_busy;

   logic                        q_push, q_pop, q_full, q_empty;
   irn_pkg::irn_ctl_type        q_in_ctl, q_head_ctl;
   logic [DW-1:0]               q_in_data, q_head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= irn_pkg::SRC_SIZE_RST;
         src_h_ff <= irn_pkg::SRC_SIZE_RST;
         tgt_w_ff <= irn_pkg::TGT_SIZE_RST;
         tgt_h_ff <= irn_pkg::TGT_SIZE_RST;
         mode_ff  <= irn_pkg::MODE_BILINEAR;
         start_ff <= 1'b1;
      end else begin
         start_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               irn_pkg::CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[8:0];
               irn_pkg::CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[8:0];
               irn_pkg::CSR_TGT_WIDTH:  tgt_w_ff <= csr_wdata;
               irn_pkg::CSR_TGT_HEIGHT: tgt_h_ff <= csr_wdata;
               irn_pkg::CSR_MODE:       mode_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      sw_c = (src_w_ff == '0) ? 13'd1 : 13'(src_w_ff);
      sh_c = (src_h_ff == '0) ? 13'd1 : 13'(src_h_ff);
      if (sw_c > 13'(MAX_SRC_WIDTH)) begin
         sw_c = 13'(MAX_SRC_WIDTH);
      end
      if (sh_c > 13'(MAX_SRC_HEIGHT)) begin
         sh_c = 13'(MAX_SRC_HEIGHT);
      end
      sw_eff = sw_c[SWW-1:0];
      sh_eff = sh_c[SHW-1:0];
      tw_eff = (tgt_w_ff == '0) ? irn_pkg::TGT_W'(1) : tgt_w_ff;
      th_eff = (tgt_h_ff == '0) ? irn_pkg::TGT_W'(1) : tgt_h_ff;
   end

   assign div_busy = start_ff || busy_x || busy_y;

   irn_div #(.NW(NWX)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend ({sw_eff, 16'd0} + NWX'(tw_eff >> 1)),
      .divisor  (tw_eff),
      .busy     (busy_x),
      .quotient (scale_x)
   );

   irn_div #(.NW(NWY)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend ({sh_eff, 16'd0} + NWY'(th_eff >> 1)),
      .divisor  (th_eff),
      .busy     (busy_y),
      .quotient (scale_y)
   );

   irn_front #(
      .XW(XW), .YW(YW), .SWW(SWW), .SHW(SHW), .SB(SAMPLE_BITS), .DW(DW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_sample_in (req_sample_in),
      .div_busy      (div_busy),
      .sw_eff        (sw_eff),
      .sh_eff        (sh_eff),
      .tw_eff        (tw_eff),
      .th_eff        (th_eff),
      .mode          (mode_ff),
      .scale_x       (scale_x),
      .scale_y       (scale_y),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_ctl         (q_in_ctl),
      .q_data        (q_in_data)
   );

   irn_queue #(.DW(DW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_ctl  (q_in_ctl),
      .push_data (q_in_data),
      .full      (q_full),
      .empty     (q_empty),
      .pop       (q_pop),
      .head_ctl  (q_head_ctl),
      .head_data (q_head_data)
   );

   irn_back #(.XW(XW), .YW(YW), .SB(SAMPLE_BITS), .DW(DW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_ctl           (q_head_ctl),
      .q_data          (q_head_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_status      (rsp_status)
   );

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> req_stall)
      else $error("word taken while scale is being computed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_pixel_value == '0)
      else $error("error word carries a nonzero pixel");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("pipeline not idle after reset");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !q_pop)
      else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: test/resample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resample_checker
// Watches the load/query and pixel channels of the resampler, keeps its own
// copy of the registers and frame store, predicts each pixel word and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module resample_checker
   import irn_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic                   req_func,
   input  wire logic [POS_W-1:0]       req_pos_x,
   input  wire logic [POS_W-1:0]       req_pos_y,
   input  wire logic [PIX_W-1:0]       req_sample_in,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [PIX_W-1:0]       rsp_pixel_value,
   input  wire logic                   rsp_status,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatches,
   output int                          outstanding,
   output int                          pixels_seen
);

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             status;
   } pixel_word_type;

   pixel_word_type   expected_pixels[$];
   logic [PIX_W-1:0] frame[0:MAX_SRC_WIDTH_DEF*MAX_SRC_HEIGHT_DEF-1];
   logic [8:0]       src_w, src_h;
   logic [12:0]      tgt_w, tgt_h;
   logic             mode;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      pixels_seen = 0;
   end

   function automatic longint src_pos(int pos, int ssize, int tsize);
      longint scale;
      longint half;
      scale = ((longint'(ssize) << 16) + (tsize >> 1)) / tsize;
      half  = ((2 * longint'(pos) + 1) * scale) >> 1;
      return half - 32768;
   endfunction

   function automatic int clamp_index(longint v, int size);
      if (v < 0) return 0;
      if (v > size - 1) return size - 1;
      return int'(v);
   endfunction

   function automatic longint round_away(longint s);
      if (s >= 0) return (s + 32768) >>> 16;
      return -((-s + 32768) >>> 16);
   endfunction

   function automatic pixel_word_type resample(int px, int py);
      int                sw, sh, tw, th, x0, x1, y0, y1;
      longint            sx, sy;
      longint unsigned   fx, fy, acc;
      pixel_word_type    r;
      sw = (src_w == 0) ? 1 : (src_w > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : src_w;
      sh = (src_h == 0) ? 1 : (src_h > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : src_h;
      tw = (tgt_w == 0) ? 1 : tgt_w;
      th = (tgt_h == 0) ? 1 : tgt_h;
      r = '0;
      if (px >= tw || py >= th) begin
         r.status = 1'b1;
         return r;
      end
      sx = src_pos(px, sw, tw);
      sy = src_pos(py, sh, th);
      if (mode == MODE_NEAREST) begin
         r.pixel = frame[clamp_index(round_away(sy), sh) * MAX_SRC_WIDTH_DEF
                         + clamp_index(round_away(sx), sw)];
      end else begin
         fx = sx & 64'hFFFF;
         fy = sy & 64'hFFFF;
         x0 = clamp_index(sx >>> 16, sw);
         y0 = clamp_index(sy >>> 16, sh);
         x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
         y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
         acc = longint'(frame[y0*MAX_SRC_WIDTH_DEF + x0]) * (65536 - fx) * (65536 - fy)
             + longint'(frame[y0*MAX_SRC_WIDTH_DEF + x1]) * fx * (65536 - fy)
             + longint'(frame[y1*MAX_SRC_WIDTH_DEF + x0]) * (65536 - fx) * fy
             + longint'(frame[y1*MAX_SRC_WIDTH_DEF + x1]) * fx * fy;
         acc = (acc + 64'h8000_0000) >> 32;
         r.pixel = (acc > 65535) ? 16'hFFFF : acc[15:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_word_type want;
      int             sw, sh;
      if (reset) begin
         src_w = SRC_SIZE_RST;
         src_h = SRC_SIZE_RST;
         tgt_w = TGT_SIZE_RST;
         tgt_h = TGT_SIZE_RST;
         mode  = MODE_BILINEAR;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: pixel word with none pending: value %0d status %0d",
                           $time, rsp_pixel_value, rsp_status);
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel !== rsp_pixel_value || want.status !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: pixel mismatch: expected value %0d status %0d, got %0d %0d",
                              $time, want.pixel, want.status, rsp_pixel_value, rsp_status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_LOAD) begin
               sw = (src_w == 0) ? 1 : (src_w > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : src_w;
               sh = (src_h == 0) ? 1 : (src_h > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : src_h;
               if (req_pos_x < sw && req_pos_y < sh)
                  frame[req_pos_y*MAX_SRC_WIDTH_DEF + req_pos_x] = req_sample_in;
            end else begin
               expected_pixels.push_back(resample(req_pos_x, req_pos_y));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w = csr_wdata[8:0];
               CSR_SRC_HEIGHT: src_h = csr_wdata[8:0];
               CSR_TGT_WIDTH:  tgt_w = csr_wdata[12:0];
               CSR_TGT_HEIGHT: tgt_h = csr_wdata[12:0];
               CSR_MODE:       mode  = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the resampler through phases of size and mode settings: each phase
// loads the whole source area, then mixes queries, reloads and stray loads,
// with bursty input and patterned output stalls. The checker predicts and
// compares every pixel word.
// ----------------------------------------------------------------------------
module tb;
   import irn_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_func = FUNC_LOAD;
   logic [POS_W-1:0]      req_pos_x = '0;
   logic [POS_W-1:0]      req_pos_y = '0;
   logic [PIX_W-1:0]      req_sample_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_value;
   logic                  rsp_status;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches, outstanding, pixels_seen;
   int cycles = 0;
   int burst_left = 0;
   int gap_max = 0;
   int stall_style = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int phases_run = 0;

   image_resample_nearest_bilinear dut (.*);

   resample_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((cycles % 11) < 5);
         endcase
      end
   end

   task automatic put_word(logic func, int x, int y, logic [PIX_W-1:0] sample);
      logic stalled;
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_func      <= func;
      req_pos_x     <= x[POS_W-1:0];
      req_pos_y     <= y[POS_W-1:0];
      req_sample_in <= sample;
      forever begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
      end
      if (func == FUNC_LOAD) loads_sent++;
      else queries_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (outstanding != 0);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic run_phase(int sw, int sh, int tw, int th, logic mode, int nq);
      int swe, she, twe, the, k, x, y, sel;
      swe = (sw == 0) ? 1 : (sw > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : sw;
      she = (sh == 0) ? 1 : (sh > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : sh;
      twe = (tw == 0) ? 1 : (tw > 4096) ? 4096 : tw;
      the = (th == 0) ? 1 : (th > 4096) ? 4096 : th;
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_SRC_WIDTH;  csr_wdata <= CSR_DATA_W'(sw); @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT; csr_wdata <= CSR_DATA_W'(sh); @(posedge clock);
      csr_index <= CSR_TGT_WIDTH;  csr_wdata <= CSR_DATA_W'(tw); @(posedge clock);
      csr_index <= CSR_TGT_HEIGHT; csr_wdata <= CSR_DATA_W'(th); @(posedge clock);
      csr_index <= CSR_MODE;       csr_wdata <= CSR_DATA_W'(mode); @(posedge clock);
      csr_we <= 1'b0;
      phases_run++;
      stall_style = $urandom_range(0, 3);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      for (y = 0; y < she; y++)
         for (x = 0; x < swe; x++) begin
            if ($urandom_range(0, 7) == 0)
               put_word(FUNC_LOAD, $urandom_range(swe, 4095), $urandom_range(0, 4095),
                        pick_sample());
            put_word(FUNC_LOAD, x, y, pick_sample());
         end
      // corners, first row/column past the target, far corner
      put_word(FUNC_QUERY, 0, 0, pick_sample());
      put_word(FUNC_QUERY, twe - 1, the - 1, pick_sample());
      put_word(FUNC_QUERY, twe - 1, 0, pick_sample());
      put_word(FUNC_QUERY, (twe < 4096) ? twe : 0, 0, pick_sample());
      put_word(FUNC_QUERY, 0, (the < 4096) ? the : 0, pick_sample());
      put_word(FUNC_QUERY, 4095, 4095, '1);
      for (k = 0; k < nq; k++) begin
         sel = $urandom_range(0, 9);
         if (k == nq / 2 && phases_run == 3) wait_drained();
         if (sel < 7) begin
            if ($urandom_range(0, 9) == 0)
               put_word(FUNC_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        pick_sample());
            else
               put_word(FUNC_QUERY, $urandom_range(0, twe - 1), $urandom_range(0, the - 1),
                        pick_sample());
         end else if (sel < 9) begin
            put_word(FUNC_LOAD, $urandom_range(0, swe - 1), $urandom_range(0, she - 1),
                     pick_sample());
         end else if (she < 4096 && $urandom_range(0, 1) == 0) begin
            put_word(FUNC_LOAD, $urandom_range(0, 4095), $urandom_range(she, 4095),
                     pick_sample());
         end else begin
            put_word(FUNC_LOAD, $urandom_range(swe, 4095), $urandom_range(0, 4095),
                     pick_sample());
         end
      end
   endtask

   initial begin
      int sw, sh, tw, th;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(4, 3, 8, 6, MODE_BILINEAR, 10);
      run_phase(4, 3, 8, 6, MODE_NEAREST, 10);
      run_phase(1, 1, 1, 1, MODE_BILINEAR, 20);
      run_phase(0, 0, 0, 0, MODE_NEAREST, 10);
      run_phase(511, 1, 8191, 3, MODE_BILINEAR, 40);
      run_phase(1, 300, 7, 4096, MODE_NEAREST, 40);
      run_phase(5, 7, 3, 2, MODE_BILINEAR, 30);
      while (loads_sent + queries_sent < 1400) begin
         sw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 10);
         sh = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 10);
         tw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48);
         th = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48);
         run_phase(sw, sh, tw, th, $urandom_range(0, 1), $urandom_range(30, 80));
      end
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Ran %0d size/mode settings: %0d loads, %0d queries, %0d pixel words checked.",
               phases_run, loads_sent, queries_sent, pixels_seen);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
